[hdl/fpms_pkg.sv]
// shared constants and types for the falling path max sum block
package fpms_pkg;

    // largest grid edge the row buffer holds
    localparam int MAX_SIZE  = 256;
    localparam int COL_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W    = 9;
    localparam int CELL_W    = 16;
    localparam int SUM_W     = 32;
    localparam int COL_OUT_W = 10;

    // result queue depth and the width of the count of results owed
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

    localparam logic signed [SUM_W-1:0]     SUM_NONE = -SUM_W'(1);
    localparam logic signed [COL_OUT_W-1:0] COL_NONE = -COL_OUT_W'(1);
    localparam logic signed [SUM_W-1:0]     SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]     SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    // one accepted cell with its grid position
    typedef struct packed {
        logic                     valid;
        logic signed [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]         col;
        logic                     first_row;
        logic                     last_row;
        logic                     first_col;
        logic                     last_col;
    } cell_req_t;

    // finished path sum of one cell
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [COL_W-1:0]        col;
        logic                    last_row;
        logic                    last_col;
    } path_res_t;

    // map a written grid size onto the last column index
    function automatic logic [COL_W-1:0] size_to_last(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] clipped;
        begin
            if (size == '0) begin
                clipped = SIZE_W'(1);
            end else if (size > SIZE_W'(MAX_SIZE)) begin
                clipped = SIZE_W'(MAX_SIZE);
            end else begin
                clipped = size;
            end
            size_to_last = COL_W'(clipped - SIZE_W'(1));
        end
    endfunction

endpackage

[hdl/fpms_row_engine.sv]
// row buffer with read-modify-write of running path sums
module fpms_row_engine import fpms_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_req_t req,
    output path_res_t res
);

    // row buffer, two read ports, one write port
    logic signed [SUM_W-1:0] row_mem [MAX_SIZE];
    logic signed [SUM_W-1:0] rd_a_reg;
    logic signed [SUM_W-1:0] rd_b_reg;

    logic [COL_W-1:0] addr_a;
    logic [COL_W-1:0] addr_b;

    // stage one registers
    logic                     s1_valid_reg;
    logic signed [CELL_W-1:0] s1_cell_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic                     s1_first_row_reg;
    logic                     s1_last_row_reg;
    logic                     s1_first_col_reg;
    logic                     s1_last_col_reg;
    logic                     fwd_a_reg;
    logic                     fwd_b_reg;
    logic signed [SUM_W-1:0]  fwd_data_reg;
    logic signed [SUM_W-1:0]  left_old_reg;

    logic signed [SUM_W-1:0]  up_val;
    logic signed [SUM_W-1:0]  up_right;
    logic signed [SUM_W-1:0]  up_left;
    logic signed [SUM_W-1:0]  best_lu;
    logic signed [SUM_W-1:0]  best3;
    logic signed [SUM_W:0]    wide_sum;
    logic signed [SUM_W-1:0]  sum_comb;

    // stage two registers
    logic                     res_valid_reg;
    logic signed [SUM_W-1:0]  res_sum_reg;
    logic [COL_W-1:0]         res_col_reg;
    logic                     res_last_row_reg;
    logic                     res_last_col_reg;

    // read the cell's own column and the one to its right
    assign addr_a = req.col;
    assign addr_b = req.col + COL_W'(1);

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            rd_a_reg <= row_mem[addr_a];
            rd_b_reg <= row_mem[addr_b];
        end
        if (s1_valid_reg) begin
            row_mem[s1_col_reg] <= sum_comb;
        end
    end

    // neighbours above, with the write of the same cycle forwarded
    always_comb begin
        up_val   = fwd_a_reg ? fwd_data_reg : rd_a_reg;
        up_right = s1_last_col_reg ? '0 : (fwd_b_reg ? fwd_data_reg : rd_b_reg);
        up_left  = s1_first_col_reg ? '0 : left_old_reg;
        best_lu  = (up_left > up_val) ? up_left : up_val;
        best3    = (up_right > best_lu) ? up_right : best_lu;
        wide_sum = (SUM_W+1)'(s1_cell_reg) + (SUM_W+1)'(best3);
        if (s1_first_row_reg) begin
            sum_comb = SUM_W'(s1_cell_reg);
        end else if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            sum_comb = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_comb = wide_sum[SUM_W-1:0];
        end
    end

    // stage one: capture the accepted cell and hazard flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_a_reg    <= 1'b0;
            fwd_b_reg    <= 1'b0;
            left_old_reg <= '0;
        end else begin
            s1_valid_reg <= req.valid;
            fwd_a_reg    <= s1_valid_reg && (s1_col_reg == addr_a);
            fwd_b_reg    <= s1_valid_reg && (s1_col_reg == addr_b);
            if (s1_valid_reg) begin
                left_old_reg <= up_val;
            end
        end
        fwd_data_reg     <= sum_comb;
        s1_cell_reg      <= req.cell_val;
        s1_col_reg       <= req.col;
        s1_first_row_reg <= req.first_row;
        s1_last_row_reg  <= req.last_row;
        s1_first_col_reg <= req.first_col;
        s1_last_col_reg  <= req.last_col;
    end

    // stage two: hand the finished sum on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= s1_valid_reg;
        end
        res_sum_reg      <= sum_comb;
        res_col_reg      <= s1_col_reg;
        res_last_row_reg <= s1_last_row_reg;
        res_last_col_reg <= s1_last_col_reg;
    end

    assign res.valid    = res_valid_reg;
    assign res.sum      = res_sum_reg;
    assign res.col      = res_col_reg;
    assign res.last_row = res_last_row_reg;
    assign res.last_col = res_last_col_reg;

endmodule

[hdl/falling_path_max_sum.sv]
// maximum falling path sum over a streamed square grid
// throughput: one cell per cycle while s_ready is high; two row reads, one write per cell
// a cell that ends a grid waits only while four results are still untaken
// reset: counters cleared, grid size 1, best reset to -1; the row buffer is not cleared
module falling_path_max_sum import fpms_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [SIZE_W-1:0]           cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [CELL_W-1:0]    s_cell_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SUM_W-1:0]     m_best_sum,
    output logic signed [COL_OUT_W-1:0] m_best_column
);

    logic [COL_W-1:0]  last_idx_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  row_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    logic signed [SUM_W-1:0]     best_reg;
    logic signed [COL_OUT_W-1:0] best_col_reg;
    logic signed [SUM_W-1:0]     best_next;
    logic signed [COL_OUT_W-1:0] best_col_next;
    logic                        take_cand;
    logic                        push;

    logic signed [SUM_W-1:0]     q_sum_reg [OUT_DEPTH];
    logic signed [COL_OUT_W-1:0] q_col_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]        wr_ptr_reg;
    logic [OUT_PTR_W-1:0]        rd_ptr_reg;
    logic [PEND_W-1:0]           q_cnt_reg;

    logic      s_fire;
    logic      m_fire;
    logic      col_last;
    logic      row_last;
    cell_req_t req;
    path_res_t res;

    // grid position of the next item
    assign col_last = (col_reg == last_idx_reg);
    assign row_last = (row_reg == last_idx_reg);
    assign s_ready  = (pending_reg < PEND_W'(OUT_DEPTH)) || !(col_last && row_last);
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (cfg_wr_en) begin
            last_idx_reg <= size_to_last(cfg_wr_data);
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (s_fire) begin
            if (col_last) begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + COL_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // request to the row engine
    assign req.valid     = s_fire;
    assign req.cell_val  = s_cell_value;
    assign req.col       = col_reg;
    assign req.first_row = (row_reg == '0);
    assign req.last_row  = row_last;
    assign req.first_col = (col_reg == '0);
    assign req.last_col  = col_last;

    fpms_row_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .res     (res)
    );

    // running best over the bottom row
    always_comb begin
        take_cand     = res.valid && res.last_row && (res.sum > best_reg);
        best_next     = take_cand ? res.sum : best_reg;
        best_col_next = take_cand ? (COL_OUT_W'(res.col) + COL_OUT_W'(1)) : best_col_reg;
        push          = res.valid && res.last_row && res.last_col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || push) begin
            best_reg     <= SUM_NONE;
            best_col_reg <= COL_NONE;
        end else begin
            best_reg     <= best_next;
            best_col_reg <= best_col_next;
        end
    end

    // results owed to the output, counted from accept
    always_comb begin
        pending_next = pending_reg;
        if (s_fire && col_last && row_last) begin
            pending_next = pending_next + PEND_W'(1);
        end
        if (m_fire) begin
            pending_next = pending_next - PEND_W'(1);
        end
    end

    // output queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_cnt_reg   <= '0;
        end else begin
            pending_reg <= pending_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            unique case ({push, m_fire})
                2'b10:   q_cnt_reg <= q_cnt_reg + PEND_W'(1);
                2'b01:   q_cnt_reg <= q_cnt_reg - PEND_W'(1);
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
        if (push) begin
            q_sum_reg[wr_ptr_reg] <= best_next;
            q_col_reg[wr_ptr_reg] <= best_col_next;
        end
    end

    assign m_valid       = (q_cnt_reg != '0);
    assign m_best_sum    = q_sum_reg[rd_ptr_reg];
    assign m_best_column = q_col_reg[rd_ptr_reg];

    // queued results never outnumber the results owed
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= pending_reg)
        else $error("output queue holds more items than owed");

    // owed results stay within the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("owed result count exceeds queue depth");

    // a grid end reaching the queue was counted at accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (pending_reg != '0))
        else $error("result pushed without an owed item");

    // an accepted grid end owes a push once through row engine stages one and two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && col_last && row_last && !cfg_wr_en) |=> ##1 push)
        else $error("grid end did not produce a result");

endmodule

[bench/falling_path_max_sum_tb.sv]
// testbench for falling_path_max_sum: streamed grids checked against a local path-sum predictor
module falling_path_max_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpms_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_CELLS = 1550;
    localparam int LONG_HOLD    = 80;

    // value mixes for the cells of one grid
    typedef enum int {
        CELLS_ANY,
        CELLS_SMALL,
        CELLS_EXTREME,
        CELLS_NEGATIVE
    } cell_mix_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]     sum;
        logic signed [COL_OUT_W-1:0] col;
    } grid_best_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]           cfg_wr_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [CELL_W-1:0]    s_cell_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [SUM_W-1:0]     m_best_sum;
    logic signed [COL_OUT_W-1:0] m_best_column;

    falling_path_max_sum dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_sum    (m_best_sum),
        .m_best_column (m_best_column)
    );

    always #2 aclk = ~aclk;

    // path-sum predictor state
    logic signed [SUM_W-1:0]     prev_row [MAX_SIZE];
    logic signed [SUM_W-1:0]     diag_left;
    int unsigned                 cur_row;
    int unsigned                 cur_col;
    logic signed [SUM_W-1:0]     best_so_far;
    logic signed [COL_OUT_W-1:0] best_col_so_far;
    logic [SIZE_W-1:0]           grid_cfg;

    grid_best_t               best_expect [$];
    logic signed [CELL_W-1:0] cell_queue [$];

    int cells_taken;
    int cells_offered;
    int send_gap;
    int stall_left;
    int hold_requests;
    int holds_done;
    bit tx_steady;
    bit rx_steady;
    int fail_count;
    int grids_checked;
    int empty_grids;
    int cells_pushed;
    int size_writes;
    int input_stalls;

    // grid size after clipping to the legal range
    function automatic int unsigned live_size();
        if (grid_cfg == '0) return 1;
        if (grid_cfg > SIZE_W'(MAX_SIZE)) return MAX_SIZE;
        return 32'(grid_cfg);
    endfunction

    function automatic logic signed [SUM_W-1:0] larger(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    task automatic restart_grid();
        diag_left       = '0;
        cur_row         = 0;
        cur_col         = 0;
        best_so_far     = SUM_NONE;
        best_col_so_far = COL_NONE;
    endtask

    // fold one accepted cell into the row sums, queue the grid result when it completes
    task automatic fold_cell(input logic signed [CELL_W-1:0] value);
        int unsigned             n;
        int unsigned             j;
        logic signed [SUM_W-1:0] up_left;
        logic signed [SUM_W-1:0] up_right;
        logic signed [SUM_W-1:0] best3;
        logic signed [SUM_W-1:0] sum;
        longint                  wide;
        grid_best_t              done;
        n = live_size();
        j = (cur_col >= n) ? 0 : cur_col;
        if (cur_row == 0) begin
            sum = SUM_W'(value);
        end else begin
            up_left  = (j == 0) ? '0 : diag_left;
            up_right = (j + 1 >= n) ? '0 : prev_row[j + 1];
            best3    = larger(larger(up_left, prev_row[j]), up_right);
            wide     = longint'(value) + longint'(best3);
            // saturate at the 32-bit limits
            if (wide > longint'(SUM_MAX)) begin
                sum = SUM_MAX;
            end else if (wide < longint'(SUM_MIN)) begin
                sum = SUM_MIN;
            end else begin
                sum = wide[SUM_W-1:0];
            end
        end
        diag_left   = prev_row[j];
        prev_row[j] = sum;
        // bottom row: strictly better wins, so the first column keeps a tie
        if (cur_row + 1 >= n && sum > best_so_far) begin
            best_so_far     = sum;
            best_col_so_far = COL_OUT_W'(j + 1);
        end
        if (j + 1 < n) begin
            cur_col = j + 1;
        end else begin
            cur_col = 0;
            if (cur_row + 1 < n) begin
                cur_row++;
            end else begin
                done.sum = best_so_far;
                done.col = best_col_so_far;
                best_expect.push_back(done);
                restart_grid();
            end
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [CELL_W-1:0] pick_cell(input cell_mix_t mix);
        int r;
        case (mix)
            CELLS_SMALL: begin
                return CELL_W'(int'($urandom_range(0, 8)) - 4);
            end
            CELLS_EXTREME: begin
                r = $urandom_range(0, 3);
                return (r == 0) ? 16'sh7fff : (r == 1) ? 16'sh8000 : (r == 2) ? -16'sd1 : 16'sd0;
            end
            CELLS_NEGATIVE: begin
                return CELL_W'(-int'($urandom_range(1, 32768)));
            end
            default: begin
                return CELL_W'($urandom());
            end
        endcase
    endfunction

    task automatic put(input logic signed [CELL_W-1:0] value);
        cell_queue.push_back(value);
        cells_pushed++;
    endtask

    task automatic queue_cells(input int count, input cell_mix_t mix);
        repeat (count) put(pick_cell(mix));
    endtask

    // size writes only happen here, with the block idle
    task automatic write_grid_size(input logic [SIZE_W-1:0] size);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        grid_cfg = size;
        restart_grid();
        size_writes++;
    endtask

    // all cells taken, all results back, then a drain wait for the pipeline
    task automatic wait_idle();
        while (cell_queue.size() != 0 || cells_taken != cells_offered || best_expect.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // cell driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || cells_taken == cells_offered)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cell_queue.size() > 0) begin
                s_cell_value <= cell_queue.pop_front();
                s_valid      <= 1'b1;
                cells_offered++;
                send_gap = pick_gap(tx_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and the occasional long hold
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_requests != holds_done) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(rx_steady);
            end
        end
    end

    // predict on accepted cells, check accepted results
    always @(posedge aclk) begin
        grid_best_t want;
        if (aresetn && s_valid && s_ready) begin
            fold_cell(s_cell_value);
            cells_taken++;
        end
        if (aresetn && s_valid && !s_ready) input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            if (best_expect.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result, got sum %0d column %0d",
                         $time, m_best_sum, m_best_column);
            end else begin
                want = best_expect.pop_front();
                grids_checked++;
                if (want.sum == SUM_NONE) empty_grids++;
                if (m_best_sum !== want.sum || m_best_column !== want.col) begin
                    fail_count++;
                    $display("%0t: grid result mismatch: expected sum %0d column %0d,",
                             $time, want.sum, want.col);
                    $display("    got sum %0d column %0d", m_best_sum, m_best_column);
                end
            end
        end
    end

    // stimulus
    initial begin
        int n;
        int side;
        int grids;
        int r;
        foreach (prev_row[i]) prev_row[i] = '0;
        grid_cfg = SIZE_W'(1);
        restart_grid();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // single-cell grids at the reset size: extremes and the no-result-above -1 case
        put(CELL_W'(32767));
        put(CELL_W'(-32768));
        put(CELL_W'(-1));
        put(CELL_W'(0));
        wait_idle();

        // size 0 behaves as 1
        write_grid_size(SIZE_W'(0));
        put(CELL_W'(5));
        wait_idle();

        // missing edge neighbours count as zero, then a tie across the bottom row
        write_grid_size(SIZE_W'(3));
        repeat (3) put(CELL_W'(-5));
        repeat (3) put(CELL_W'(1));
        repeat (3) put(CELL_W'(0));
        wait_idle();

        // grid cut short, the next size write restarts it
        queue_cells(4, CELLS_ANY);
        wait_idle();
        write_grid_size(SIZE_W'(2));
        put(CELL_W'(7));
        put(CELL_W'(7));
        put(CELL_W'(0));
        put(CELL_W'(0));
        wait_idle();

        // long receiver hold while single-cell grids keep arriving
        write_grid_size(SIZE_W'(1));
        tx_steady = 1'b1;
        hold_requests++;
        queue_cells(24, CELLS_ANY);
        wait_idle();
        tx_steady = 1'b0;

        // largest sizes, each grid left partial past the first row
        write_grid_size(SIZE_W'(511));
        queue_cells(MAX_SIZE + $urandom_range(1, 60), CELLS_ANY);
        wait_idle();
        write_grid_size(SIZE_W'(MAX_SIZE));
        queue_cells(MAX_SIZE + $urandom_range(1, 60), CELLS_SMALL);
        wait_idle();

        // random phases: one size each, whole grids, now and then a broken tail
        while (cells_pushed < RANDOM_CELLS) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                n = 0;
            end else if (r < 45) begin
                n = $urandom_range(1, 3);
            end else if (r < 85) begin
                n = $urandom_range(4, 8);
            end else begin
                n = $urandom_range(9, 16);
            end
            write_grid_size(SIZE_W'(n));
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 19) == 0) hold_requests++;
            side = (n == 0) ? 1 : n;
            if (side == 1) begin
                grids = $urandom_range(4, 24);
            end else if (side <= 3) begin
                grids = $urandom_range(2, 8);
            end else if (side <= 8) begin
                grids = $urandom_range(1, 4);
            end else begin
                grids = 1;
            end
            repeat (grids) queue_cells(side * side, cell_mix_t'($urandom_range(0, 3)));
            if (side > 1 && $urandom_range(0, 9) == 0)
                queue_cells($urandom_range(1, side * side - 1), CELLS_ANY);
            wait_idle();
        end

        $display("covered %0d cells over %0d size writes, sizes 0 through 511",
                 cells_pushed, size_writes);
        $display("input stalled %0d cycles, checked %0d grid results, %0d with no sum above -1",
                 input_stalls, grids_checked, empty_grids);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard
    initial begin
        #4ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hdl/fpms_pkg.sv
hdl/fpms_row_engine.sv
hdl/falling_path_max_sum.sv
bench/falling_path_max_sum_tb.sv
